[rtl/kcbb_pkg.sv]
// Package for the key color bounding box block.
// Result type, register indexes and default sizes; no dependencies.
`default_nettype none

package kcbb_pkg;

    localparam int OUT_W = 10;
    localparam int KEY_W = 8;
    localparam int CFG_W = 11;
    localparam int IDX_W = 2;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [KEY_W-1:0] RST_KEY    = '0;
    localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd320;
    localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd200;

    typedef enum logic [IDX_W-1:0] {
        REG_KEY_COLOR    = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } t_reg_idx;

    typedef logic [OUT_W-1:0] t_coord;

    typedef struct packed {
        logic   found;
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_result;

endpackage

`default_nettype wire

[rtl/kcbb_tracker.sv]
// Column/row counters and min/max trackers for one frame.
// Depends on kcbb_pkg for the result struct and field widths.
`default_nettype none

module kcbb_tracker import kcbb_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [KEY_W-1:0] i_pixel,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [CFG_W-1:0] i_width,
    input  wire logic [CFG_W-1:0] i_height,
    output logic                  o_frame_end,
    output t_result               o_res
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CWP = CW + 1;
    localparam int RWP = RW + 1;

    logic [CW-1:0] r_col, r_min_col, r_max_col, n_min_col, n_max_col;
    logic [RW-1:0] r_row, r_min_row, r_max_row, n_min_row, n_max_row;
    logic          r_found, n_found;
    logic [CWP-1:0] w_eff;
    logic [RWP-1:0] h_eff;
    logic           hit, row_end;

    // zero acts as one, oversize clamps to the maximum
    always_comb begin
        if (i_width == '0) begin
            w_eff = CWP'(1);
        end else if (32'(i_width) > MAX_WIDTH) begin
            w_eff = CWP'(MAX_WIDTH);
        end else begin
            w_eff = CWP'(i_width);
        end
        if (i_height == '0) begin
            h_eff = RWP'(1);
        end else if (32'(i_height) > MAX_HEIGHT) begin
            h_eff = RWP'(MAX_HEIGHT);
        end else begin
            h_eff = RWP'(i_height);
        end
    end

    assign hit         = (i_pixel != i_key);
    assign row_end     = (CWP'(r_col) + CWP'(1)) >= w_eff;
    assign o_frame_end = row_end && ((RWP'(r_row) + RWP'(1)) >= h_eff);

    always_comb begin
        n_found   = r_found;
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        if (hit) begin
            n_found = 1'b1;
            if (!r_found) begin
                n_min_col = r_col;
                n_max_col = r_col;
                n_min_row = r_row;
                n_max_row = r_row;
            end else begin
                if (r_col < r_min_col) n_min_col = r_col;
                if (r_col > r_max_col) n_max_col = r_col;
                if (r_row < r_min_row) n_min_row = r_row;
                if (r_row > r_max_row) n_max_row = r_row;
            end
        end
    end

    always_comb begin
        o_res = '0;
        if (n_found) begin
            o_res.found  = 1'b1;
            o_res.left   = OUT_W'(n_min_col);
            o_res.top    = OUT_W'(n_min_row);
            o_res.right  = OUT_W'(n_max_col);
            o_res.bottom = OUT_W'(n_max_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && o_frame_end)) begin
            r_col     <= '0;
            r_row     <= '0;
            r_found   <= 1'b0;
            r_min_col <= CW'(MAX_WIDTH - 1);
            r_max_col <= '0;
            r_min_row <= RW'(MAX_HEIGHT - 1);
            r_max_row <= '0;
        end else if (i_step) begin
            r_found   <= n_found;
            r_min_col <= n_min_col;
            r_max_col <= n_max_col;
            r_min_row <= n_min_row;
            r_max_row <= n_max_row;
            if (row_end) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/kcbb_out.sv]
// Result register with valid/ready handshake toward the consumer.
// Depends on kcbb_pkg for the result struct.
`default_nettype none

module kcbb_out import kcbb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_ready,
    output logic         o_valid,
    output logic         o_free,
    output t_result      o_res
);

    logic    r_vld;
    t_result r_res;

    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

[rtl/key_color_bounding_box.sv]
// Bounding box of non-key pixels: one pixel per cycle in, one box per frame out.
// Pixels pass an input register, then the tracker updates counters and min/max;
// the box of a frame is loaded into the result register as the last pixel leaves
// the input register. Sustained rate is one pixel per clock, set by the
// single compare-and-update pass of the tracker; the input stalls only while a
// finished box waits in the result register and another frame end arrives.
// Depends on kcbb_pkg, kcbb_tracker and kcbb_out.
`default_nettype none

module key_color_bounding_box import kcbb_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [KEY_W-1:0] i_pixel,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_found,
    output logic [OUT_W-1:0]      o_left,
    output logic [OUT_W-1:0]      o_top,
    output logic [OUT_W-1:0]      o_right,
    output logic [OUT_W-1:0]      o_bottom
);

    logic [KEY_W-1:0] r_key;
    logic [CFG_W-1:0] r_width, r_height;
    logic             r_in_vld;
    logic [KEY_W-1:0] r_pixel;
    logic             frame_end, out_free, advance, accept;
    t_result          res, out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= RST_KEY;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_KEY_COLOR:    r_key    <= i_cfg_data[KEY_W-1:0];
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a pixel that closes a frame waits until the result register is free
    assign advance = r_in_vld && (!frame_end || out_free);
    assign o_ready = !r_in_vld || advance;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel <= i_pixel;
        end
    end

    kcbb_tracker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_pixel     (r_pixel),
        .i_key       (r_key),
        .i_width     (r_width),
        .i_height    (r_height),
        .o_frame_end (frame_end),
        .o_res       (res)
    );

    kcbb_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && frame_end),
        .i_res   (res),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    assign o_found  = out_res.found;
    assign o_left   = out_res.left;
    assign o_top    = out_res.top;
    assign o_right  = out_res.right;
    assign o_bottom = out_res.bottom;

endmodule

`default_nettype wire

[rtl/kcbb_checker.sv]
// Port-level checks for key_color_bounding_box, attached by bind.
// Depends on kcbb_pkg for field widths.
`default_nettype none

module kcbb_checker import kcbb_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_ready,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic             i_found,
    input wire logic [OUT_W-1:0] i_left,
    input wire logic [OUT_W-1:0] i_top,
    input wire logic [OUT_W-1:0] i_right,
    input wire logic [OUT_W-1:0] i_bottom
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_found) && $stable(i_left) && $stable(i_top) &&
            $stable(i_right) && $stable(i_bottom))
        else $error("result payload changed while stalled");

    a_empty_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |->
            i_left == '0 && i_top == '0 && i_right == '0 && i_bottom == '0)
        else $error("empty frame with nonzero box");

    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_found |-> i_left <= i_right && i_top <= i_bottom)
        else $error("box corners out of order");

    // with the result register empty nothing can hold off a new pixel
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind key_color_bounding_box kcbb_checker u_kcbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_found     (o_found),
    .i_left      (o_left),
    .i_top       (o_top),
    .i_right     (o_right),
    .i_bottom    (o_bottom)
);

`default_nettype wire
